// ----- rtl/usvt_pkg.sv -----
package usvt_pkg;

  localparam int CAPACITY = 16;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int FUNC_W   = 3;
  localparam int STAT_W   = 2;
  localparam int OCNT_W   = 5;

  localparam logic [FUNC_W-1:0] FUNC_SIZE     = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_CONTAINS = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_INSERT   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_LIST     = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ABSENT  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_PRESENT = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_LIST,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic              valid;
    logic [STAT_W-1:0] status;
    logic              found;
    logic [OCNT_W-1:0] count;
    logic [DATA_W-1:0] entry_value;
    logic              entry_valid;
    logic              last;
  } res_t;

endpackage

// ----- rtl/usvt_ram.sv -----
module usvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/usvt_ctrl.sv -----
module usvt_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [usvt_pkg::FUNC_W-1:0]         in_func,
  input  logic signed [usvt_pkg::DATA_W-1:0]  in_value,
  input  logic [usvt_pkg::DATA_W-1:0]         rd_data,
  output logic                                busy,
  output usvt_pkg::mem_req_t                  mem_req,
  output usvt_pkg::res_t                      res
);

  usvt_pkg::state_t                     state_r, state_nxt;
  logic [usvt_pkg::FUNC_W-1:0]          func_r, func_nxt;
  logic [usvt_pkg::DATA_W-1:0]          val_r, val_nxt;
  logic [usvt_pkg::CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [usvt_pkg::CNT_W-1:0]           idx_r, idx_nxt;
  logic                                 pend_r, pend_nxt;
  logic [usvt_pkg::ADDR_W-1:0]          cmp_idx_r, cmp_idx_nxt;

  logic issue;
  logic match;
  logic miss;
  logic list_last;
  logic is_lookup;

  // read issued this cycle; compare/consume happens in the next cycle on rd_data
  assign issue     = (idx_r < cnt_r);
  assign match     = pend_r && (rd_data == val_r);
  assign miss      = !pend_r && !issue;
  assign list_last = ((usvt_pkg::CNT_W'(cmp_idx_r) + 1'b1) == cnt_r);
  assign is_lookup = (in_func == usvt_pkg::FUNC_CONTAINS) ||
                     (in_func == usvt_pkg::FUNC_INSERT) ||
                     (in_func == usvt_pkg::FUNC_REMOVE);
  assign busy      = (state_r != usvt_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      usvt_pkg::ST_IDLE: begin
        if (start) begin
          if (is_lookup) begin
            state_nxt = usvt_pkg::ST_SCAN;
          end else if (in_func == usvt_pkg::FUNC_LIST) begin
            state_nxt = usvt_pkg::ST_LIST;
          end else begin
            state_nxt = usvt_pkg::ST_RESP;
          end
        end
      end
      usvt_pkg::ST_SCAN: begin
        if (match) begin
          state_nxt = (func_r == usvt_pkg::FUNC_REMOVE) ? usvt_pkg::ST_SHIFT
                                                         : usvt_pkg::ST_IDLE;
        end else if (miss) begin
          state_nxt = usvt_pkg::ST_IDLE;
        end
      end
      usvt_pkg::ST_SHIFT: begin
        if (miss) begin
          state_nxt = usvt_pkg::ST_IDLE;
        end
      end
      usvt_pkg::ST_LIST: begin
        if ((pend_r && list_last) || (cnt_r == '0)) begin
          state_nxt = usvt_pkg::ST_IDLE;
        end
      end
      usvt_pkg::ST_RESP: begin
        state_nxt = usvt_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = usvt_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    func_nxt    = func_r;
    val_nxt     = val_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    pend_nxt    = 1'b0;
    cmp_idx_nxt = idx_r[usvt_pkg::ADDR_W-1:0];

    mem_req.we    = 1'b0;
    mem_req.waddr = cnt_r[usvt_pkg::ADDR_W-1:0];
    mem_req.wdata = val_r;
    mem_req.raddr = idx_r[usvt_pkg::ADDR_W-1:0];

    res.valid       = 1'b0;
    res.status      = usvt_pkg::STAT_OK;
    res.found       = 1'b0;
    res.entry_value = '0;
    res.entry_valid = 1'b0;
    res.last        = 1'b1;

    case (state_r)
      usvt_pkg::ST_IDLE: begin
        if (start) begin
          func_nxt = in_func;
          val_nxt  = in_value;
          idx_nxt  = '0;
        end
      end
      usvt_pkg::ST_SCAN: begin
        if (issue) begin
          idx_nxt  = idx_r + 1'b1;
          pend_nxt = 1'b1;
        end
        if (match) begin
          if (func_r == usvt_pkg::FUNC_REMOVE) begin
            // compaction starts reading the entry right after the hit
            idx_nxt  = usvt_pkg::CNT_W'(cmp_idx_r) + 1'b1;
            pend_nxt = 1'b0;
          end else begin
            res.valid  = 1'b1;
            res.found  = 1'b1;
            res.status = (func_r == usvt_pkg::FUNC_INSERT) ? usvt_pkg::STAT_PRESENT
                                                            : usvt_pkg::STAT_OK;
          end
        end else if (miss) begin
          res.valid = 1'b1;
          if (func_r == usvt_pkg::FUNC_INSERT) begin
            if (cnt_r == usvt_pkg::CNT_W'(usvt_pkg::CAPACITY)) begin
              res.status = usvt_pkg::STAT_FULL;
            end else begin
              mem_req.we = 1'b1;
              cnt_nxt    = cnt_r + 1'b1;
              res.status = usvt_pkg::STAT_OK;
            end
          end else begin
            res.status = usvt_pkg::STAT_ABSENT;
          end
        end
      end
      usvt_pkg::ST_SHIFT: begin
        if (issue) begin
          idx_nxt  = idx_r + 1'b1;
          pend_nxt = 1'b1;
        end
        if (pend_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = cmp_idx_r - 1'b1;
          mem_req.wdata = rd_data;
        end
        if (miss) begin
          cnt_nxt   = cnt_r - 1'b1;
          res.valid = 1'b1;
          res.found = 1'b1;
        end
      end
      usvt_pkg::ST_LIST: begin
        if (issue) begin
          idx_nxt  = idx_r + 1'b1;
          pend_nxt = 1'b1;
        end
        if (pend_r) begin
          res.valid       = 1'b1;
          res.entry_value = rd_data;
          res.entry_valid = 1'b1;
          res.last        = list_last;
        end else if (cnt_r == '0) begin
          res.valid = 1'b1;
        end
      end
      usvt_pkg::ST_RESP: begin
        res.valid = 1'b1;
      end
      default: begin
      end
    endcase

    res.count = usvt_pkg::OCNT_W'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= usvt_pkg::ST_IDLE;
      cnt_r     <= '0;
      pend_r    <= 1'b0;
      idx_r     <= '0;
      func_r    <= usvt_pkg::FUNC_SIZE;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      pend_r    <= pend_nxt;
      idx_r     <= idx_nxt;
      func_r    <= func_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r     <= val_nxt;
    cmp_idx_r <= cmp_idx_nxt;
  end

endmodule

// ----- rtl/unique_value_set_table.sv -----
// Ordered set of up to CAPACITY distinct 32-bit values held in one registered-read RAM.
// Size answers without a scan; contains/insert scan until the hit or the end, list reads
// every entry in order, remove scans to the hit and then shifts each later entry down.
// The RAM scan reads one entry per cycle; one request at a time, the next taken at the
// edge that takes the last result. Synchronous active-low reset empties the table;
// results cannot be stalled.
module unique_value_set_table (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [usvt_pkg::FUNC_W-1:0]         in_func,
  input  logic signed [usvt_pkg::DATA_W-1:0]  in_value,
  output logic                                out_valid,
  output logic [usvt_pkg::STAT_W-1:0]         out_status,
  output logic                                out_found,
  output logic [usvt_pkg::OCNT_W-1:0]         out_count,
  output logic signed [usvt_pkg::DATA_W-1:0]  out_entry_value,
  output logic                                out_entry_valid,
  output logic                                out_last
);

  usvt_pkg::mem_req_t             mem_req;
  usvt_pkg::res_t                 res;
  usvt_pkg::res_t                 res_r;
  logic                           valid_r;
  logic [usvt_pkg::DATA_W-1:0]    rd_data;

  usvt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_func  (in_func),
    .in_value (in_value),
    .rd_data  (rd_data),
    .busy     (busy),
    .mem_req  (mem_req),
    .res      (res)
  );

  usvt_ram #(
    .WIDTH (usvt_pkg::DATA_W),
    .DEPTH (usvt_pkg::CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (rd_data)
  );

  // result register: one strobe per transaction, one per entry for a list with entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res;
  end

  assign out_valid       = valid_r;
  assign out_status      = res_r.status;
  assign out_found       = res_r.found;
  assign out_count       = res_r.count;
  assign out_entry_value = res_r.entry_value;
  assign out_entry_valid = res_r.entry_valid;
  assign out_last        = res_r.last;

endmodule

// ----- rtl/usvt_chk.sv -----
module usvt_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic [usvt_pkg::FUNC_W-1:0]         in_func,
  input logic signed [usvt_pkg::DATA_W-1:0]  in_value,
  input logic                                out_valid,
  input logic [usvt_pkg::STAT_W-1:0]         out_status,
  input logic                                out_found,
  input logic [usvt_pkg::OCNT_W-1:0]         out_count,
  input logic signed [usvt_pkg::DATA_W-1:0]  out_entry_value,
  input logic                                out_entry_valid,
  input logic                                out_last
);

  // a taken request makes the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // only list entries may be non-final
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_entry_valid) |-> out_last)
    else $error("non-list result without last");

  a_entry_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_entry_valid) |-> (out_status == usvt_pkg::STAT_OK && !out_found))
    else $error("list entry with bad status or found");

  // more list entries still to come
  a_list_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> busy)
    else $error("list transaction idle before last entry");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == usvt_pkg::STAT_FULL) |-> !out_found)
    else $error("full status with found set");

endmodule

bind unique_value_set_table usvt_chk u_usvt_chk (.*);
